/* hdl/note_sequence_player_top_macros.svh */
// ----------------------------------------------------------------------------
// note sequence player assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef NOTE_SEQUENCE_PLAYER_TOP_MACROS_SVH
`define NOTE_SEQUENCE_PLAYER_TOP_MACROS_SVH

// checked only out of reset
`define NSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define NSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/nsp_pkg.sv */
// ----------------------------------------------------------------------------
// nsp_pkg
// shared types and constants of the note sequence player
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned FREQ_W      = 11;
  localparam int unsigned DUR_IN_W    = 12;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned NUM_W       = 24;
  localparam int unsigned GAP_W       = 8;
  localparam int unsigned POS_OUT_W   = 10;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [NUM_W-1:0] TONE_NUM_RST = 24'd328125;
  localparam logic [GAP_W-1:0] GAP_RST      = 8'd10;

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EFFECT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TONE_NUMERATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS      = 2'd1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_WRITE,
    OP_START,
    OP_EFFECT,
    OP_STOP,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_ON  = 2'd1,
    MODE_GAP = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUR_RD,
    S_DUR_CHK,
    S_NOTE_RD,
    S_NOTE_CHK,
    S_DIV,
    S_EMIT
  } back_state_e;

  typedef struct packed {
    op_e                 op;
    logic [ADDR_W-1:0]   addr;
    logic [FREQ_W-1:0]   freq;
    logic [DUR_IN_W-1:0] dur;
    logic [LEN_W-1:0]    len;
    logic                loop_flag;
  } nsp_item_t;

  typedef struct packed {
    logic [1:0]           play_state;
    logic                 tone_on;
    logic [NUM_W-1:0]     period_reload;
    logic [POS_OUT_W-1:0] note_position;
  } nsp_result_t;

endpackage

`default_nettype wire

/* hdl/nsp_ram.sv */
// ----------------------------------------------------------------------------
// nsp_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_ram #(
  parameter int unsigned WIDTH = 23,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hdl/nsp_front.sv */
// ----------------------------------------------------------------------------
// nsp_front
// accepts items, decodes the command and queues the decoded item
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_front
  import nsp_pkg::*;
#(
  parameter int unsigned NOTE_DEPTH = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output      logic                full,
  input  wire logic [CMD_W-1:0]    cmd_i,
  input  wire logic [ADDR_W-1:0]   note_address_i,
  input  wire logic [FREQ_W-1:0]   note_freq_i,
  input  wire logic [DUR_IN_W-1:0] note_dur_i,
  input  wire logic [LEN_W-1:0]    seq_length_i,
  input  wire logic                loop_flag_i,
  output      nsp_item_t           item_o,
  output      logic                item_valid_o,
  input  wire logic                item_pop_i
);

  localparam int unsigned AW     = $clog2(NOTE_DEPTH);
  localparam int unsigned LCW    = ((AW + 1) > LEN_W) ? (AW + 1) : LEN_W;
  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = PTR_W + 1;
  localparam int unsigned MOD_SH = 27;
  localparam int unsigned MOD_MW = 24;
  localparam int unsigned MOD_M  = ((32'd1 << MOD_SH) + NOTE_DEPTH - 1) / NOTE_DEPTH;
  localparam int unsigned PW     = ADDR_W + MOD_MW;

  nsp_item_t        queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  nsp_item_t        item_new;
  logic             push_ok;

  // remainder of the address by the store depth through a scaled reciprocal
  function automatic logic [ADDR_W-1:0] addr_mod(input logic [ADDR_W-1:0] a);
    logic [PW-1:0] prod;
    logic [PW-1:0] quo;
    prod = PW'(a) * PW'(MOD_M);
    quo  = prod >> MOD_SH;
    return ADDR_W'(PW'(a) - quo * PW'(NOTE_DEPTH));
  endfunction

  always_comb begin
    item_new           = '0;
    item_new.addr      = addr_mod(note_address_i);
    item_new.freq      = note_freq_i;
    item_new.dur       = note_dur_i;
    item_new.loop_flag = loop_flag_i;
    if (LCW'(seq_length_i) > LCW'(NOTE_DEPTH)) begin
      item_new.len = LEN_W'(NOTE_DEPTH);
    end else begin
      item_new.len = seq_length_i;
    end
    case (cmd_i)
      CMD_TICK:   item_new.op = OP_TICK;
      CMD_WRITE:  item_new.op = OP_WRITE;
      CMD_START:  item_new.op = OP_START;
      CMD_EFFECT: item_new.op = OP_EFFECT;
      CMD_STOP:   item_new.op = OP_STOP;
      default:    item_new.op = OP_NONE;
    endcase
  end

  assign full         = (count_q == CNT_W'(QUEUE_DEPTH));
  assign push_ok      = push && !full;
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (item_pop_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push_ok && !item_pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_ok && item_pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      queue_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

`default_nettype wire

/* hdl/nsp_div.sv */
// ----------------------------------------------------------------------------
// nsp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_div
  import nsp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  dividend_i,
  input  wire logic [FREQ_W-1:0] divisor_i,
  output      logic              done_o,
  output      logic [NUM_W-1:0]  quotient_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FREQ_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [FREQ_W-1:0] div_q, div_d;
  logic [FREQ_W:0]   rem_sh;

  assign rem_sh = {rem_q[FREQ_W-1:0], quo_q[NUM_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = rem_sh - {1'b0, div_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* hdl/nsp_back.sv */
// ----------------------------------------------------------------------------
// nsp_back
// carries out decoded items: note store, sequencer state, reload division
// and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_back
  import nsp_pkg::*;
#(
  parameter int unsigned NOTE_DEPTH = 1024,
  parameter int unsigned DUR_BITS   = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire nsp_item_t            item_i,
  input  wire logic                 item_valid_i,
  output      logic                 item_pop_o,
  input  wire logic [NUM_W-1:0]     tone_numerator_i,
  input  wire logic [GAP_W-1:0]     gap_ticks_i,
  output      logic                 empty_o,
  input  wire logic                 pop_i,
  output      logic [1:0]           play_state_o,
  output      logic                 tone_on_o,
  output      logic [NUM_W-1:0]     period_reload_o,
  output      logic [POS_OUT_W-1:0] note_position_o
);

  localparam int unsigned AW    = $clog2(NOTE_DEPTH);
  localparam int unsigned AW1   = AW + 1;
  localparam int unsigned CW    = (AW1 > LEN_W) ? AW1 : LEN_W;
  localparam int unsigned ENT_W = FREQ_W + DUR_BITS;
  localparam logic [DUR_BITS-1:0] DUR_MAX = {DUR_BITS{1'b1}};

  back_state_e         state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [AW-1:0]       seq_base_q, seq_base_d;
  logic [LEN_W-1:0]    seq_len_q, seq_len_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic                looping_q, looping_d;
  logic [DUR_BITS-1:0] elapsed_q, elapsed_d;
  logic                saved_valid_q, saved_valid_d;
  logic [AW-1:0]       saved_base_q, saved_base_d;
  logic [LEN_W-1:0]    saved_len_q, saved_len_d;
  logic [AW-1:0]       saved_pos_q, saved_pos_d;
  logic [NUM_W-1:0]    reload_q, reload_d;
  logic                tone_q, tone_d;
  logic                out_valid_q, out_valid_d;
  nsp_result_t         out_q, out_d;

  logic [AW:0]         addr_sum;
  logic [AW-1:0]       cur_addr;
  logic                ram_we;
  logic [ENT_W-1:0]    ram_wdata;
  logic [ENT_W-1:0]    ram_rdata;
  logic [FREQ_W-1:0]   ram_freq;
  logic [DUR_BITS-1:0] ram_dur;
  logic [DUR_BITS-1:0] elapsed_inc;
  logic                run_last;
  logic                div_start;
  logic                div_done;
  logic [NUM_W-1:0]    div_quo;

  assign addr_sum = {1'b0, seq_base_q} + {1'b0, pos_q};
  assign cur_addr = (addr_sum >= AW1'(NOTE_DEPTH)) ? AW'(addr_sum - AW1'(NOTE_DEPTH))
                                                    : AW'(addr_sum);
  assign ram_wdata   = {item_i.freq, DUR_BITS'(item_i.dur)};
  assign ram_freq    = ram_rdata[DUR_BITS +: FREQ_W];
  assign ram_dur     = ram_rdata[DUR_BITS-1:0];
  assign elapsed_inc = (elapsed_q < DUR_MAX) ? elapsed_q + DUR_BITS'(1) : elapsed_q;
  assign run_last    = (CW'(pos_q) + CW'(1)) >= CW'(seq_len_q);

  nsp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NOTE_DEPTH)
  ) u_note_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(item_i.addr)),
    .wdata_i (ram_wdata),
    .raddr_i (cur_addr),
    .rdata_o (ram_rdata)
  );

  nsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tone_numerator_i),
    .divisor_i  (ram_freq),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    seq_base_d    = seq_base_q;
    seq_len_d     = seq_len_q;
    pos_d         = pos_q;
    looping_d     = looping_q;
    elapsed_d     = elapsed_q;
    saved_valid_d = saved_valid_q;
    saved_base_d  = saved_base_q;
    saved_len_d   = saved_len_q;
    saved_pos_d   = saved_pos_q;
    reload_d      = reload_q;
    tone_d        = tone_q;
    out_valid_d   = out_valid_q && !pop_i;
    out_d         = out_q;
    item_pop_o    = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i && (!out_valid_q || pop_i)) begin
          item_pop_o = 1'b1;
          state_d    = S_EMIT;
          case (item_i.op)
            OP_TICK: begin
              if (mode_q != MODE_OFF) begin
                elapsed_d = elapsed_inc;
                if (mode_q == MODE_ON) begin
                  state_d = S_DUR_RD;
                end else if (elapsed_inc >= DUR_BITS'(gap_ticks_i)) begin
                  state_d = S_NOTE_RD;
                  if (!run_last) begin
                    pos_d = pos_q + AW'(1);
                  end else if (looping_q) begin
                    pos_d = '0;
                  end else if (saved_valid_q) begin
                    seq_base_d    = saved_base_q;
                    seq_len_d     = saved_len_q;
                    pos_d         = saved_pos_q;
                    looping_d     = 1'b1;
                    saved_valid_d = 1'b0;
                  end else begin
                    mode_d    = MODE_OFF;
                    elapsed_d = '0;
                    reload_d  = '0;
                    tone_d    = 1'b0;
                    state_d   = S_EMIT;
                  end
                end
              end
            end
            OP_WRITE: begin
              ram_we = 1'b1;
            end
            OP_START: begin
              seq_base_d = AW'(item_i.addr);
              seq_len_d  = item_i.len;
              pos_d      = '0;
              looping_d  = item_i.loop_flag;
              state_d    = S_NOTE_RD;
            end
            OP_EFFECT: begin
              if (mode_q != MODE_OFF && looping_q) begin
                saved_base_d  = seq_base_q;
                saved_len_d   = seq_len_q;
                saved_pos_d   = pos_q;
                saved_valid_d = 1'b1;
              end
              seq_base_d = AW'(item_i.addr);
              seq_len_d  = item_i.len;
              pos_d      = '0;
              looping_d  = 1'b0;
              state_d    = S_NOTE_RD;
            end
            OP_STOP: begin
              mode_d    = MODE_OFF;
              elapsed_d = '0;
              reload_d  = '0;
              tone_d    = 1'b0;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_DUR_RD: begin
        state_d = S_DUR_CHK;
      end
      S_DUR_CHK: begin
        if (elapsed_q >= ram_dur) begin
          mode_d    = MODE_GAP;
          elapsed_d = '0;
          reload_d  = '0;
          tone_d    = 1'b0;
        end
        state_d = S_EMIT;
      end
      S_NOTE_RD: begin
        state_d = S_NOTE_CHK;
      end
      S_NOTE_CHK: begin
        if (ram_freq == '0) begin
          mode_d    = MODE_ON;
          elapsed_d = '0;
          reload_d  = '0;
          tone_d    = 1'b0;
          state_d   = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          reload_d  = (div_quo == '0) ? '0 : div_quo - NUM_W'(1);
          tone_d    = 1'b1;
          mode_d    = MODE_ON;
          elapsed_d = '0;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid_d         = 1'b1;
        out_d.play_state    = mode_q;
        out_d.tone_on       = (mode_q == MODE_ON) && tone_q;
        out_d.period_reload = ((mode_q == MODE_ON) && tone_q) ? reload_q : '0;
        out_d.note_position = POS_OUT_W'(pos_q);
        state_d             = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mode_q        <= MODE_OFF;
      seq_base_q    <= '0;
      seq_len_q     <= '0;
      pos_q         <= '0;
      looping_q     <= 1'b0;
      elapsed_q     <= '0;
      saved_valid_q <= 1'b0;
      saved_base_q  <= '0;
      saved_len_q   <= '0;
      saved_pos_q   <= '0;
      reload_q      <= '0;
      tone_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      mode_q        <= mode_d;
      seq_base_q    <= seq_base_d;
      seq_len_q     <= seq_len_d;
      pos_q         <= pos_d;
      looping_q     <= looping_d;
      elapsed_q     <= elapsed_d;
      saved_valid_q <= saved_valid_d;
      saved_base_q  <= saved_base_d;
      saved_len_q   <= saved_len_d;
      saved_pos_q   <= saved_pos_d;
      reload_q      <= reload_d;
      tone_q        <= tone_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o         = !out_valid_q;
  assign play_state_o    = out_q.play_state;
  assign tone_on_o       = out_q.tone_on;
  assign period_reload_o = out_q.period_reload;
  assign note_position_o = out_q.note_position;

endmodule

`default_nettype wire

/* hdl/note_sequence_player_top.sv */
// ----------------------------------------------------------------------------
// note_sequence_player_top
// single-channel note sequencer with note store and tone reload divider
// ----------------------------------------------------------------------------
// Every item gives exactly one result. Items enter a four-deep command queue
// and are carried out one at a time. A write, stop or idle tick goes straight
// from idle to the emit step; a tick while a note sounds first makes one note
// store read; an item that starts a sounding note (start, effect, or a tick
// that ends a gap) reads the note store and then waits for the reload divider,
// which produces one quotient bit per cycle, while a rest note skips the
// divider. A result must be popped before the next item is carried out.
// Configuration writes are always ready.
`default_nettype none

module note_sequence_player_top
  import nsp_pkg::*;
#(
  parameter int unsigned NOTE_DEPTH = 1024,
  parameter int unsigned DUR_BITS   = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output      logic                 full,
  input  wire logic [CMD_W-1:0]     cmd_i,
  input  wire logic [ADDR_W-1:0]    note_address_i,
  input  wire logic [FREQ_W-1:0]    note_freq_i,
  input  wire logic [DUR_IN_W-1:0]  note_dur_i,
  input  wire logic [LEN_W-1:0]     seq_length_i,
  input  wire logic                 loop_flag_i,
  output      logic                 empty,
  input  wire logic                 pop,
  output      logic [1:0]           play_state_o,
  output      logic                 tone_on_o,
  output      logic [NUM_W-1:0]     period_reload_o,
  output      logic [POS_OUT_W-1:0] note_position_o,
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [NUM_W-1:0]     cfg_data_i
);

  logic [NUM_W-1:0] tone_numerator_q, tone_numerator_d;
  logic [GAP_W-1:0] gap_ticks_q, gap_ticks_d;
  nsp_item_t        item;
  logic             item_valid;
  logic             item_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    tone_numerator_d = tone_numerator_q;
    gap_ticks_d      = gap_ticks_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TONE_NUMERATOR: tone_numerator_d = cfg_data_i;
        REG_GAP_TICKS:      gap_ticks_d      = cfg_data_i[GAP_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_numerator_q <= TONE_NUM_RST;
      gap_ticks_q      <= GAP_RST;
    end else begin
      tone_numerator_q <= tone_numerator_d;
      gap_ticks_q      <= gap_ticks_d;
    end
  end

  nsp_front #(
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd_i),
    .note_address_i (note_address_i),
    .note_freq_i    (note_freq_i),
    .note_dur_i     (note_dur_i),
    .seq_length_i   (seq_length_i),
    .loop_flag_i    (loop_flag_i),
    .item_o         (item),
    .item_valid_o   (item_valid),
    .item_pop_i     (item_pop)
  );

  nsp_back #(
    .NOTE_DEPTH (NOTE_DEPTH),
    .DUR_BITS   (DUR_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .item_valid_i     (item_valid),
    .item_pop_o       (item_pop),
    .tone_numerator_i (tone_numerator_q),
    .gap_ticks_i      (gap_ticks_q),
    .empty_o          (empty),
    .pop_i            (pop),
    .play_state_o     (play_state_o),
    .tone_on_o        (tone_on_o),
    .period_reload_o  (period_reload_o),
    .note_position_o  (note_position_o)
  );

endmodule

`default_nettype wire

/* hdl/nsp_checker.sv */
// ----------------------------------------------------------------------------
// nsp_checker
// port-level checks of the note sequence player, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "note_sequence_player_top_macros.svh"

module nsp_checker
  import nsp_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire logic [1:0]           play_state_o,
  input wire logic                 tone_on_o,
  input wire logic [NUM_W-1:0]     period_reload_o,
  input wire logic [POS_OUT_W-1:0] note_position_o
);

  // a sounding tone is only reported while a note plays
  `NSP_ASSERT(a_tone_needs_note, !empty && tone_on_o |-> play_state_o == MODE_ON, "tone on outside a note")

  // a nonzero reload only comes with a sounding tone
  `NSP_ASSERT(a_reload_needs_tone, !empty && period_reload_o != '0 |-> tone_on_o, "reload while silent")

  // no result waits during reset
  `NSP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> empty, "result present in reset")

  // an unpopped result stays
  `NSP_ASSERT(a_result_held, !empty && !pop |=> !empty, "result lost without pop")

  // an unpopped result keeps its value
  `NSP_ASSERT(a_result_stable, !empty && !pop |=> $stable(play_state_o) && $stable(note_position_o) && $stable(period_reload_o), "result changed without pop")

endmodule

bind note_sequence_player_top nsp_checker u_nsp_checker (.*);

`default_nettype wire
